// ----- rtl/core/shs_pkg.sv -----
`timescale 1ns / 1ps

package shs_pkg;

    typedef logic [31:0] word_t;

    // input item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // word queue between the byte packer and the compression core
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int WINDOW_WORDS = 16;
    localparam int HASH_WORDS   = 8;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [3:0] LAST_WORD  = 4'd15;
    localparam logic [3:0] LEN_HI_POS = 4'd14;
    localparam logic [3:0] LEN_FITS   = 4'd13;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_DIGEST_WORD = 3'd7;

    localparam word_t INIT_H [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // one queue entry: a 32-bit message word plus block framing
    typedef struct packed {
        word_t word;
        logic  blk_end;
        logic  fin;
        logic  err;
    } shs_beat_t;

    typedef struct packed {
        logic      valid;
        shs_beat_t beat;
    } shs_qbeat_t;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- rtl/core/shs_if.sv -----
`timescale 1ns / 1ps

interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        length_error;

    modport source (output valid, output digest_word, output word_index, output last,
                    output length_error, input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    input length_error, output ready);
endinterface

// ----- rtl/core/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each beat on msg carries one message byte
// (kind 0) or a finish request (kind 1). A finish pads the message, runs the
// last one or two blocks and returns the digest on the digest channel as eight
// 32-bit words, first word first, with last set on the eighth and
// length_error set on all eight when more than 2^61-1 bytes were taken; the
// hasher then starts over with the initial hash. Bytes are taken one per
// cycle while the queue has room and no padding is under way, and packed
// into words that wait in a four-entry queue, so input keeps flowing for up
// to 16 bytes while a block compresses or a digest waits to be taken. The
// compression core loads a block from the queue a word at a time, then runs
// the rounds on its single round unit and adds the result into the hash. A
// finish queues padding words to the end of the block, and of one more block
// when the length does not fit; no new item is taken until they are queued.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    shs_in_if.sink      msg,
    shs_out_if.source   digest
);

    shs_qbeat_t push;
    shs_qbeat_t head;
    logic       full;
    logic       pop;

    shs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .push  (push),
        .full  (full)
    );

    shs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    shs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .digest (digest)
    );

endmodule

// ----- rtl/core/shs_fifo.sv -----
`timescale 1ns / 1ps

module shs_fifo
    import shs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  shs_qbeat_t push,
    output logic       full,
    output shs_qbeat_t head,
    input  logic       pop
);

    shs_beat_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.beat  = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.beat;
        end
    end

endmodule

// ----- rtl/core/shs_front.sv -----
`timescale 1ns / 1ps

module shs_front
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    shs_in_if.sink       msg,
    output shs_qbeat_t   push,
    input  logic         full
);

    typedef enum logic {F_ACC, F_PAD} front_state_t;

    front_state_t state_reg, state_next;
    logic [23:0]  acc_reg, acc_next;
    logic [1:0]   lane_reg, lane_next;
    logic [3:0]   wcnt_reg, wcnt_next;
    logic [60:0]  cnt_reg, cnt_next;
    logic         ovf_reg, ovf_next;
    logic         first_reg, first_next;
    logic         len_blk_reg, len_blk_next;

    logic         beat_ok;
    word_t        mark_word;
    word_t        pad_word;

    assign msg.ready = (state_reg == F_ACC) && !full;
    assign beat_ok   = msg.valid && msg.ready;

    // first padding word: bytes held so far, then the marker byte
    always_comb
    begin
        case (lane_reg)
            2'd0:    mark_word = {PAD_MARK, 24'd0};
            2'd1:    mark_word = {acc_reg[7:0], PAD_MARK, 16'd0};
            2'd2:    mark_word = {acc_reg[15:0], PAD_MARK, 8'd0};
            2'd3:    mark_word = {acc_reg[23:0], PAD_MARK};
            default: mark_word = '0;
        endcase
    end

    always_comb
    begin
        if (first_reg)
        begin
            pad_word = mark_word;
        end
        else if (len_blk_reg && wcnt_reg == LEN_HI_POS)
        begin
            pad_word = cnt_reg[60:29];
        end
        else if (len_blk_reg && wcnt_reg == LAST_WORD)
        begin
            pad_word = {cnt_reg[28:0], 3'b000};
        end
        else
        begin
            pad_word = '0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        lane_next    = lane_reg;
        wcnt_next    = wcnt_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        first_next   = first_reg;
        len_blk_next = len_blk_reg;
        push         = '0;

        case (state_reg)
            F_ACC:
            begin
                if (beat_ok && msg.kind == KIND_DATA)
                begin
                    acc_next  = {acc_reg[15:0], msg.data_byte};
                    lane_next = 2'(lane_reg + 1'b1);
                    if (lane_reg == 2'd3)
                    begin
                        push.valid        = 1'b1;
                        push.beat.word    = {acc_reg, msg.data_byte};
                        push.beat.blk_end = (wcnt_reg == LAST_WORD);
                        wcnt_next         = 4'(wcnt_reg + 1'b1);
                    end
                    // saturate the length and flag it
                    if (&cnt_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (beat_ok)
                begin
                    state_next   = F_PAD;
                    first_next   = 1'b1;
                    len_blk_next = (wcnt_reg <= LEN_FITS);
                end
            end

            F_PAD:
            begin
                if (!full)
                begin
                    push.valid        = 1'b1;
                    push.beat.word    = pad_word;
                    push.beat.blk_end = (wcnt_reg == LAST_WORD);
                    push.beat.fin     = (wcnt_reg == LAST_WORD) && len_blk_reg;
                    push.beat.err     = ovf_reg;
                    wcnt_next         = 4'(wcnt_reg + 1'b1);
                    first_next        = 1'b0;
                    if (wcnt_reg == LAST_WORD)
                    begin
                        if (len_blk_reg)
                        begin
                            state_next = F_ACC;
                            lane_next  = '0;
                            cnt_next   = '0;
                            ovf_next   = 1'b0;
                        end
                        else
                        begin
                            // marker spilled past the length slot: one more block
                            len_blk_next = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = F_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_ACC;
            lane_reg    <= '0;
            wcnt_reg    <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            first_reg   <= 1'b0;
            len_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lane_reg    <= lane_next;
            wcnt_reg    <= wcnt_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            first_reg   <= first_next;
            len_blk_reg <= len_blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// ----- rtl/core/shs_core.sv -----
`timescale 1ns / 1ps

module shs_core
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  shs_qbeat_t   head,
    output logic         pop,
    shs_out_if.source    digest
);

    typedef enum logic [1:0] {B_LOAD, B_ROUND, B_UPDATE, B_OUT} core_state_t;

    core_state_t state_reg, state_next;
    word_t       w_reg    [WINDOW_WORDS];
    word_t       w_next   [WINDOW_WORDS];
    word_t       s_reg    [HASH_WORDS];
    word_t       s_next   [HASH_WORDS];
    word_t       hash_reg [HASH_WORDS];
    word_t       hash_next[HASH_WORDS];
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_err_reg, out_err_next;

    word_t       t1, t2, ch, maj, sched;

    assign pop = (state_reg == B_LOAD) && head.valid;

    assign digest.valid        = out_valid_reg;
    assign digest.digest_word  = out_word_reg;
    assign digest.word_index   = out_idx_reg;
    assign digest.last         = (out_idx_reg == LAST_DIGEST_WORD);
    assign digest.length_error = out_err_reg;

    always_comb
    begin
        ch    = (s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]);
        maj   = (s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]);
        t1    = s_reg[7] + big_sigma1(s_reg[4]) + ch + round_k(rnd_reg) + w_reg[0];
        t2    = big_sigma0(s_reg[0]) + maj;
        sched = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        hash_next      = hash_reg;
        rnd_next       = rnd_reg;
        fin_next       = fin_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            B_LOAD:
            begin
                if (pop)
                begin
                    for (int i = 0; i < WINDOW_WORDS - 1; i++)
                    begin
                        w_next[i] = w_reg[i+1];
                    end
                    w_next[WINDOW_WORDS-1] = head.beat.word;
                    if (head.beat.blk_end)
                    begin
                        fin_next   = head.beat.fin;
                        err_next   = head.beat.err;
                        s_next     = hash_reg;
                        rnd_next   = '0;
                        state_next = B_ROUND;
                    end
                end
            end

            B_ROUND:
            begin
                // window slides by one word per round
                for (int i = 0; i < WINDOW_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[WINDOW_WORDS-1] = sched;
                s_next[7] = s_reg[6];
                s_next[6] = s_reg[5];
                s_next[5] = s_reg[4];
                s_next[4] = s_reg[3] + t1;
                s_next[3] = s_reg[2];
                s_next[2] = s_reg[1];
                s_next[1] = s_reg[0];
                s_next[0] = t1 + t2;
                rnd_next  = 6'(rnd_reg + 1'b1);
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = B_UPDATE;
                end
            end

            B_UPDATE:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + s_reg[i];
                end
                if (fin_reg)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = hash_reg[0] + s_reg[0];
                    out_idx_next   = '0;
                    out_err_next   = err_reg;
                    state_next     = B_OUT;
                end
                else
                begin
                    state_next = B_LOAD;
                end
            end

            B_OUT:
            begin
                if (digest.ready)
                begin
                    if (out_idx_reg == LAST_DIGEST_WORD)
                    begin
                        out_valid_next = 1'b0;
                        hash_next      = INIT_H;
                        state_next     = B_LOAD;
                    end
                    else
                    begin
                        out_idx_next  = 3'(out_idx_reg + 1'b1);
                        out_word_next = hash_reg[3'(out_idx_reg + 1'b1)];
                    end
                end
            end

            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_LOAD;
            hash_reg      <= INIT_H;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_err_reg   <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            rnd_reg       <= rnd_next;
            fin_reg       <= fin_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_err_reg   <= out_err_next;
            out_word_reg  <= out_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        s_reg <= s_next;
    end

endmodule

// ----- rtl/core/shs_checker.sv -----
`timescale 1ns / 1ps

module shs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [2:0]  out_index,
    input logic        out_last,
    input logic        out_err
);

    // a stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("digest word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 3'd7)))
    else $error("last does not match word index");

    // digest words follow one another with rising index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last
        |=> out_valid && out_index == 3'($past(out_index) + 3'd1))
    else $error("digest word missing or out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_err == $past(out_err))
    else $error("length error flag changed within a digest");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_word  (digest.digest_word),
    .out_index (digest.word_index),
    .out_last  (digest.last),
    .out_err   (digest.length_error)
);
